### rtl/rec_pkg.sv
// Shared types and constants for the RISC-V extension classifier.
`default_nettype none
package rec_pkg;

    localparam int unsigned MASK_W  = 25;
    localparam int unsigned CLASS_W = 5;

    typedef enum logic [CLASS_W-1:0] {
        EC_ILLEGAL     = 5'd0,
        EC_I           = 5'd1,
        EC_M           = 5'd2,
        EC_A           = 5'd3,
        EC_C           = 5'd4,
        EC_ZICSR       = 5'd5,
        EC_ZIFENCEI    = 5'd6,
        EC_F           = 5'd7,
        EC_D           = 5'd8,
        EC_V           = 5'd9,
        EC_ZBA         = 5'd10,
        EC_ZBB         = 5'd11,
        EC_ZBS         = 5'd12,
        EC_ZICOND      = 5'd13,
        EC_ZIHINTPAUSE = 5'd14,
        EC_ZIHINTNTL   = 5'd15,
        EC_ZIMOP       = 5'd16,
        EC_ZCMOP       = 5'd17,
        EC_ZICBOM      = 5'd18,
        EC_ZICBOP      = 5'd19,
        EC_ZICBOZ      = 5'd20,
        EC_ZAWRS       = 5'd21,
        EC_ZFA         = 5'd22,
        EC_ZFHMIN      = 5'd23,
        EC_SVINVAL     = 5'd24,
        EC_H           = 5'd25
    } t_ext_class;

    typedef enum logic [6:0] {
        OPC_LUI      = 7'h37,
        OPC_AUIPC    = 7'h17,
        OPC_JAL      = 7'h6F,
        OPC_JALR     = 7'h67,
        OPC_BRANCH   = 7'h63,
        OPC_LOAD     = 7'h03,
        OPC_STORE    = 7'h23,
        OPC_OP_IMM   = 7'h13,
        OPC_MISC_MEM = 7'h0F,
        OPC_OP_IMM32 = 7'h1B,
        OPC_OP       = 7'h33,
        OPC_OP32     = 7'h3B,
        OPC_AMO      = 7'h2F,
        OPC_SYSTEM   = 7'h73,
        OPC_LOAD_FP  = 7'h07,
        OPC_STORE_FP = 7'h27,
        OPC_MADD     = 7'h43,
        OPC_MSUB     = 7'h47,
        OPC_NMSUB    = 7'h4B,
        OPC_NMADD    = 7'h4F,
        OPC_OP_FP    = 7'h53,
        OPC_OP_V     = 7'h57
    } t_opcode;

    typedef enum logic {
        CFG_RV64_MODE  = 1'b0,
        CFG_EXT_ENABLE = 1'b1
    } t_cfg_idx;

    localparam logic [31:0] PAUSE_WORD   = 32'h0100000F;
    localparam logic [31:0] WRS_NTO_WORD = 32'h00D00073;
    localparam logic [31:0] WRS_STO_WORD = 32'h01D00073;

    typedef struct packed {
        t_ext_class ext_class;
        logic       enabled;
    } t_dec_result;

endpackage
`default_nettype wire

### rtl/rec_decoder.sv
// Combinational extension classification of one instruction word.
`default_nettype none
module rec_decoder (
    input  wire logic [31:0]               i_instr,
    input  wire logic                      i_rv64_mode,
    input  wire logic [rec_pkg::MASK_W-1:0] i_ext_enable_mask,
    output rec_pkg::t_dec_result           o_result
);

    function automatic logic on(input rec_pkg::t_ext_class c,
                                input logic [rec_pkg::MASK_W-1:0] m);
        logic [4:0] idx;
        idx = 5'(c) - 5'd1;
        return m[idx];
    endfunction

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [5:0]  f6;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [11:0] imm;
    rec_pkg::t_ext_class cls;

    assign opc = i_instr[6:0];
    assign f3  = i_instr[14:12];
    assign f6  = i_instr[31:26];
    assign f7  = i_instr[31:25];
    assign rd  = i_instr[11:7];
    assign rs1 = i_instr[19:15];
    assign rs2 = i_instr[24:20];
    assign imm = i_instr[31:20];

    always_comb begin
        logic [rec_pkg::MASK_W-1:0] m;
        m   = i_ext_enable_mask;
        cls = rec_pkg::EC_ILLEGAL;
        case (opc)
            rec_pkg::OPC_LUI, rec_pkg::OPC_AUIPC, rec_pkg::OPC_JAL, rec_pkg::OPC_JALR,
            rec_pkg::OPC_BRANCH, rec_pkg::OPC_LOAD, rec_pkg::OPC_STORE: begin
                cls = rec_pkg::EC_I;
            end
            rec_pkg::OPC_OP_IMM: begin
                cls = rec_pkg::EC_I;
                if (f3 == 3'd1) begin
                    if (f6 == 6'h00) cls = rec_pkg::EC_I;
                    else if (f6 == 6'h18) cls = rec_pkg::EC_ZBB;
                    else if (f6 == 6'h0A || f6 == 6'h12 || f6 == 6'h1A) cls = rec_pkg::EC_ZBS;
                    else cls = rec_pkg::EC_ILLEGAL;
                end else if (f3 == 3'd5) begin
                    if (f6 == 6'h00 || f6 == 6'h10) cls = rec_pkg::EC_I;
                    else if (f6 == 6'h18 || f6 == 6'h0A || f6 == 6'h1A) cls = rec_pkg::EC_ZBB;
                    else if (f6 == 6'h12) cls = rec_pkg::EC_ZBS;
                    else cls = rec_pkg::EC_ILLEGAL;
                end else if (f3 == 3'd6 && on(rec_pkg::EC_ZICBOP, m) && rd == 5'd0
                             && (rs2 == 5'd0 || rs2 == 5'd1 || rs2 == 5'd3)) begin
                    cls = rec_pkg::EC_ZICBOP;
                end
            end
            rec_pkg::OPC_MISC_MEM: begin
                if (f3 == 3'd1) cls = rec_pkg::EC_ZIFENCEI;
                else if (f3 == 3'd2) begin
                    if (imm <= 12'd2) cls = rec_pkg::EC_ZICBOM;
                    else if (imm == 12'd4) cls = rec_pkg::EC_ZICBOZ;
                    else cls = rec_pkg::EC_ILLEGAL;
                end else if (i_instr == rec_pkg::PAUSE_WORD
                             && on(rec_pkg::EC_ZIHINTPAUSE, m)) begin
                    cls = rec_pkg::EC_ZIHINTPAUSE;
                end else cls = rec_pkg::EC_I;
            end
            rec_pkg::OPC_OP_IMM32: begin
                cls = rec_pkg::EC_ILLEGAL;
                if (i_rv64_mode) begin
                    if (f3 == 3'd0) cls = rec_pkg::EC_I;
                    else if (f3 == 3'd1) begin
                        if (f6 == 6'h00) cls = rec_pkg::EC_I;
                        else if (f6 == 6'h02) cls = rec_pkg::EC_ZBA;
                        else if (f6 == 6'h18) cls = rec_pkg::EC_ZBB;
                    end else if (f3 == 3'd5) begin
                        if (f6 == 6'h00 || f6 == 6'h10) cls = rec_pkg::EC_I;
                        else if (f6 == 6'h18) cls = rec_pkg::EC_ZBB;
                    end
                end
            end
            rec_pkg::OPC_OP: begin
                case (f7)
                    7'h01: cls = rec_pkg::EC_M;
                    7'h00: cls = rec_pkg::EC_I;
                    7'h20: begin
                        if (f3 == 3'd0 || f3 == 3'd5) cls = rec_pkg::EC_I;
                        else if (f3 == 3'd4 || f3 == 3'd6 || f3 == 3'd7) cls = rec_pkg::EC_ZBB;
                    end
                    7'h10: if (f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd6) cls = rec_pkg::EC_ZBA;
                    7'h05: if (f3 >= 3'd4) cls = rec_pkg::EC_ZBB;
                    7'h30: if (f3 == 3'd1 || f3 == 3'd5) cls = rec_pkg::EC_ZBB;
                    7'h24: if (f3 == 3'd1 || f3 == 3'd5) cls = rec_pkg::EC_ZBS;
                    7'h34: if (f3 == 3'd1) cls = rec_pkg::EC_ZBS;
                    7'h07: if (f3 == 3'd5 || f3 == 3'd7) cls = rec_pkg::EC_ZICOND;
                    7'h14: if (f3 == 3'd1) cls = rec_pkg::EC_ZBS;
                    default: cls = rec_pkg::EC_ILLEGAL;
                endcase
            end
            rec_pkg::OPC_OP32: begin
                if (i_rv64_mode) begin
                    case (f7)
                        7'h01: cls = rec_pkg::EC_M;
                        7'h00: cls = rec_pkg::EC_I;
                        7'h20: if (f3 == 3'd0 || f3 == 3'd5) cls = rec_pkg::EC_I;
                        7'h04: begin
                            if (f3 == 3'd0) cls = rec_pkg::EC_ZBA;
                            else if (f3 == 3'd4) cls = rec_pkg::EC_ZBB;
                        end
                        7'h10: if (f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd6) cls = rec_pkg::EC_ZBA;
                        7'h30: if (f3 == 3'd1 || f3 == 3'd5) cls = rec_pkg::EC_ZBB;
                        default: cls = rec_pkg::EC_ILLEGAL;
                    endcase
                end
            end
            rec_pkg::OPC_AMO: cls = rec_pkg::EC_A;
            rec_pkg::OPC_SYSTEM: begin
                cls = rec_pkg::EC_ZICSR;
                if (f3 == 3'd4) begin
                    if (i_instr[31]) cls = rec_pkg::EC_ZIMOP;
                    else if (on(rec_pkg::EC_H, m) && f7 >= 7'h30 && f7 <= 7'h37)
                        cls = rec_pkg::EC_H;
                    else cls = rec_pkg::EC_ILLEGAL;
                end else if (i_instr == rec_pkg::WRS_NTO_WORD
                             || i_instr == rec_pkg::WRS_STO_WORD) begin
                    cls = on(rec_pkg::EC_ZAWRS, m) ? rec_pkg::EC_ZAWRS : rec_pkg::EC_ILLEGAL;
                end else if (f3 == 3'd0 && rd == 5'd0) begin
                    if (on(rec_pkg::EC_H, m) && (f7 == 7'h11 || f7 == 7'h31))
                        cls = rec_pkg::EC_H;
                    else if (on(rec_pkg::EC_H, m) && on(rec_pkg::EC_SVINVAL, m)
                             && (f7 == 7'h13 || f7 == 7'h33))
                        cls = rec_pkg::EC_H;
                    else if (f7 == 7'h0B)
                        cls = on(rec_pkg::EC_SVINVAL, m) ? rec_pkg::EC_SVINVAL
                                                         : rec_pkg::EC_ILLEGAL;
                    else if (f7 == 7'h0C && rs1 == 5'd0 && (rs2 == 5'd0 || rs2 == 5'd1))
                        cls = on(rec_pkg::EC_SVINVAL, m) ? rec_pkg::EC_SVINVAL
                                                         : rec_pkg::EC_ILLEGAL;
                end
            end
            rec_pkg::OPC_LOAD_FP, rec_pkg::OPC_STORE_FP: begin
                if (f3 == 3'd3) cls = rec_pkg::EC_D;
                else if (f3 == 3'd2) cls = rec_pkg::EC_F;
                else if (f3 == 3'd1)
                    cls = on(rec_pkg::EC_ZFHMIN, m) ? rec_pkg::EC_ZFHMIN : rec_pkg::EC_ILLEGAL;
                else if (f3 == 3'd0 || f3 >= 3'd5) cls = rec_pkg::EC_V;
                else cls = rec_pkg::EC_ILLEGAL;
            end
            rec_pkg::OPC_MADD, rec_pkg::OPC_MSUB, rec_pkg::OPC_NMSUB, rec_pkg::OPC_NMADD: begin
                cls = (f7[1:0] == 2'd1) ? rec_pkg::EC_D : rec_pkg::EC_F;
            end
            rec_pkg::OPC_OP_FP: begin
                if (f7 == 7'h20 || f7 == 7'h21) cls = rec_pkg::EC_D;
                else cls = f7[0] ? rec_pkg::EC_D : rec_pkg::EC_F;
                if (on(rec_pkg::EC_ZFHMIN, m)
                    && (((f7 == 7'h20 || f7 == 7'h21) && rs2 == 5'd2)
                        || (f7 == 7'h22 && (rs2 == 5'd0 || rs2 == 5'd1))
                        || ((f7 == 7'h72 || f7 == 7'h7A) && rs2 == 5'd0)))
                    cls = rec_pkg::EC_ZFHMIN;
                if (on(rec_pkg::EC_ZFA, m)
                    && (((f7 == 7'h78 || f7 == 7'h79) && rs2 == 5'd1)
                        || ((f7 == 7'h14 || f7 == 7'h15) && (f3 == 3'd2 || f3 == 3'd3))
                        || ((f7 == 7'h20 || f7 == 7'h21) && (rs2 == 5'd4 || rs2 == 5'd5))
                        || (f7 == 7'h61 && rs2 == 5'd8)
                        || ((f7 == 7'h50 || f7 == 7'h51) && (f3 == 3'd4 || f3 == 3'd5))))
                    cls = rec_pkg::EC_ZFA;
            end
            rec_pkg::OPC_OP_V: cls = rec_pkg::EC_V;
            default: cls = rec_pkg::EC_ILLEGAL;
        endcase
    end

    assign o_result.ext_class = cls;
    assign o_result.enabled   = (cls != rec_pkg::EC_ILLEGAL) && on(cls, i_ext_enable_mask);

endmodule
`default_nettype wire

### rtl/riscv_extension_classifier_unit.sv
// Top level of the RISC-V extension classifier: config registers and two-stage pipeline.
//
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             i_instr_word
// result    out        o_strobe (one cycle)      o_ext_class, o_class_enabled
// config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// One instruction per cycle; busy stays low.
// After acceptance a word passes through the input register, decode and the result register.
// Synchronous active-low reset clears the pipeline and restores rv64_mode=1, all enables set.
// The receiver cannot stall; the config port is always ready.
`default_nettype none
module riscv_extension_classifier_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output wire logic                      busy,
    input  wire logic [31:0]               i_instr_word,
    output wire logic                      o_strobe,
    output wire logic [rec_pkg::CLASS_W-1:0] o_ext_class,
    output wire logic                      o_class_enabled,
    input  wire logic                      i_cfg_valid,
    output wire logic                      o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [rec_pkg::MASK_W-1:0] i_cfg_data
);

    logic                       r_vld;
    logic [31:0]                r_instr;
    logic                       r_strobe;
    rec_pkg::t_dec_result       r_res;
    logic                       r_rv64;
    logic [rec_pkg::MASK_W-1:0] r_mask;
    rec_pkg::t_dec_result       n_res;
    logic                       accept;
    logic                       cfg_wr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv64 <= 1'b1;
            r_mask <= '1;
        end else if (cfg_wr) begin
            case (rec_pkg::t_cfg_idx'(i_cfg_index))
                rec_pkg::CFG_RV64_MODE:  r_rv64 <= i_cfg_data[0];
                rec_pkg::CFG_EXT_ENABLE: r_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= accept;
            r_strobe <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_instr <= i_instr_word;
        if (r_vld)  r_res   <= n_res;
    end

    rec_decoder u_dec (
        .i_instr          (r_instr),
        .i_rv64_mode      (r_rv64),
        .i_ext_enable_mask(r_mask),
        .o_result         (n_res)
    );

    assign o_strobe        = r_strobe;
    assign o_ext_class     = r_res.ext_class;
    assign o_class_enabled = r_res.enabled;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("accepted transaction did not produce a result");

    a_illegal_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_ext_class == rec_pkg::EC_ILLEGAL) |-> !o_class_enabled)
        else $error("illegal class reported as enabled");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_ext_class <= rec_pkg::EC_H)
        else $error("class code out of range");

    a_no_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_ext_class != rec_pkg::EC_C) && (o_ext_class != rec_pkg::EC_ZIHINTNTL)
                     && (o_ext_class != rec_pkg::EC_ZCMOP))
        else $error("class never produced by 32-bit decode was reported");

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for riscv_extension_classifier_unit: directed corners, gating, random words.
`default_nettype none
module tb;
    import rec_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam logic [MASK_W-1:0] MASK_ALL = {MASK_W{1'b1}};

    localparam logic [31:0] CORNER_WORDS [25] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h4000_5013, 32'h6000_1013,
        32'h4800_1013, 32'h0000_6013, PAUSE_WORD,    32'h0000_100F, 32'h0040_200F,
        32'h0000_001B, 32'h0200_0033, 32'h2000_203B, 32'h0E00_5033, 32'h0000_202F,
        WRS_NTO_WORD,  32'h1800_0073, 32'h2200_0073, 32'h6000_4073, 32'h8000_4073,
        32'h0000_1007, 32'hF010_0053, 32'h4020_0053, 32'h0000_0057, 32'h0200_0043
    };

    localparam logic [6:0] OPCODE_SET [22] = '{
        OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
        OPC_OP_IMM, OPC_MISC_MEM, OPC_OP_IMM32, OPC_OP, OPC_OP32, OPC_AMO, OPC_SYSTEM,
        OPC_LOAD_FP, OPC_STORE_FP, OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD,
        OPC_OP_FP, OPC_OP_V
    };

    localparam logic [6:0] FUNCT7_SET [28] = '{
        7'h00, 7'h01, 7'h20, 7'h10, 7'h05, 7'h30, 7'h24, 7'h34, 7'h07, 7'h14,
        7'h04, 7'h11, 7'h31, 7'h13, 7'h33, 7'h0B, 7'h0C, 7'h78, 7'h79, 7'h15,
        7'h21, 7'h61, 7'h50, 7'h51, 7'h22, 7'h72, 7'h7A, 7'h02
    };

    localparam logic [5:0] FUNCT6_SET [7] = '{6'h00, 6'h18, 6'h0A, 6'h12, 6'h1A, 6'h10, 6'h02};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [31:0]       i_instr_word = '0;
    logic              o_strobe;
    logic [CLASS_W-1:0] o_ext_class;
    logic              o_class_enabled;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = 1'b0;
    logic [MASK_W-1:0] i_cfg_data = '0;

    logic              rv64_q = 1'b1;
    logic [MASK_W-1:0] mask_q = MASK_ALL;
    logic              idle_en = 1'b0;
    t_dec_result       predicted_q [$];
    t_dec_result       due;
    int unsigned       mismatch_cnt = 0;
    int unsigned       cycle_cnt = 0;

    riscv_extension_classifier_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_instr_word    (i_instr_word),
        .o_strobe        (o_strobe),
        .o_ext_class     (o_ext_class),
        .o_class_enabled (o_class_enabled),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic class_on(t_ext_class c);
        return mask_q[int'(c) - 1];
    endfunction

    function automatic logic [MASK_W-1:0] class_bit(t_ext_class c);
        return MASK_W'(1) << (int'(c) - 1);
    endfunction

    function automatic t_ext_class classify_instr(logic [31:0] w);
        logic [2:0]  f3;
        logic [5:0]  f6;
        logic [6:0]  f7;
        logic [11:0] imm;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        f3  = w[14:12];
        f6  = w[31:26];
        f7  = w[31:25];
        imm = w[31:20];
        rd  = w[11:7];
        rs1 = w[19:15];
        rs2 = w[24:20];
        case (w[6:0])
            OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE:
                return EC_I;
            OPC_OP_IMM: begin
                if (f3 == 3'd1) begin
                    if (f6 == 6'h00) return EC_I;
                    if (f6 == 6'h18) return EC_ZBB;
                    if (f6 == 6'h0A || f6 == 6'h12 || f6 == 6'h1A) return EC_ZBS;
                    return EC_ILLEGAL;
                end
                if (f3 == 3'd5) begin
                    if (f6 == 6'h00 || f6 == 6'h10) return EC_I;
                    if (f6 == 6'h18 || f6 == 6'h0A || f6 == 6'h1A) return EC_ZBB;
                    if (f6 == 6'h12) return EC_ZBS;
                    return EC_ILLEGAL;
                end
                // prefetch hints
                if (f3 == 3'd6 && class_on(EC_ZICBOP) && rd == '0 &&
                    (rs2 == 5'd0 || rs2 == 5'd1 || rs2 == 5'd3)) return EC_ZICBOP;
                return EC_I;
            end
            OPC_MISC_MEM: begin
                if (f3 == 3'd1) return EC_ZIFENCEI;
                if (f3 == 3'd2) begin
                    if (imm <= 12'd2) return EC_ZICBOM;
                    if (imm == 12'd4) return EC_ZICBOZ;
                    return EC_ILLEGAL;
                end
                if (w == PAUSE_WORD && class_on(EC_ZIHINTPAUSE)) return EC_ZIHINTPAUSE;
                return EC_I;
            end
            OPC_OP_IMM32: begin
                if (!rv64_q) return EC_ILLEGAL;
                if (f3 == 3'd0) return EC_I;
                if (f3 == 3'd1) begin
                    if (f6 == 6'h00) return EC_I;
                    if (f6 == 6'h02) return EC_ZBA;
                    if (f6 == 6'h18) return EC_ZBB;
                    return EC_ILLEGAL;
                end
                if (f3 == 3'd5) begin
                    if (f6 == 6'h00 || f6 == 6'h10) return EC_I;
                    if (f6 == 6'h18) return EC_ZBB;
                end
                return EC_ILLEGAL;
            end
            OPC_OP: begin
                case (f7)
                    7'h01: return EC_M;
                    7'h00: return EC_I;
                    7'h20: begin
                        if (f3 == 3'd0 || f3 == 3'd5) return EC_I;
                        if (f3 == 3'd4 || f3 == 3'd6 || f3 == 3'd7) return EC_ZBB;
                        return EC_ILLEGAL;
                    end
                    7'h10: return (f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd6) ? EC_ZBA : EC_ILLEGAL;
                    7'h05: return (f3 >= 3'd4) ? EC_ZBB : EC_ILLEGAL;
                    7'h30: return (f3 == 3'd1 || f3 == 3'd5) ? EC_ZBB : EC_ILLEGAL;
                    7'h24: return (f3 == 3'd1 || f3 == 3'd5) ? EC_ZBS : EC_ILLEGAL;
                    7'h34: return (f3 == 3'd1) ? EC_ZBS : EC_ILLEGAL;
                    7'h07: return (f3 == 3'd5 || f3 == 3'd7) ? EC_ZICOND : EC_ILLEGAL;
                    7'h14: return (f3 == 3'd1) ? EC_ZBS : EC_ILLEGAL;
                    default: return EC_ILLEGAL;
                endcase
            end
            OPC_OP32: begin
                if (!rv64_q) return EC_ILLEGAL;
                case (f7)
                    7'h01: return EC_M;
                    7'h00: return EC_I;
                    7'h20: return (f3 == 3'd0 || f3 == 3'd5) ? EC_I : EC_ILLEGAL;
                    7'h04: begin
                        if (f3 == 3'd0) return EC_ZBA;
                        if (f3 == 3'd4) return EC_ZBB;
                        return EC_ILLEGAL;
                    end
                    7'h10: return (f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd6) ? EC_ZBA : EC_ILLEGAL;
                    7'h30: return (f3 == 3'd1 || f3 == 3'd5) ? EC_ZBB : EC_ILLEGAL;
                    default: return EC_ILLEGAL;
                endcase
            end
            OPC_AMO: return EC_A;
            OPC_SYSTEM: begin
                if (f3 == 3'd4) begin
                    if (w[31]) return EC_ZIMOP;
                    if (class_on(EC_H) && f7 >= 7'h30 && f7 <= 7'h37) return EC_H;
                    return EC_ILLEGAL;
                end
                if (w == WRS_NTO_WORD || w == WRS_STO_WORD)
                    return class_on(EC_ZAWRS) ? EC_ZAWRS : EC_ILLEGAL;
                if (f3 == 3'd0 && rd == '0) begin
                    if (class_on(EC_H) && (f7 == 7'h11 || f7 == 7'h31)) return EC_H;
                    if (class_on(EC_H) && class_on(EC_SVINVAL) && (f7 == 7'h13 || f7 == 7'h33))
                        return EC_H;
                    if (f7 == 7'h0B) return class_on(EC_SVINVAL) ? EC_SVINVAL : EC_ILLEGAL;
                    if (f7 == 7'h0C && rs1 == '0 && (rs2 == 5'd0 || rs2 == 5'd1))
                        return class_on(EC_SVINVAL) ? EC_SVINVAL : EC_ILLEGAL;
                end
                return EC_ZICSR;
            end
            OPC_LOAD_FP, OPC_STORE_FP: begin
                if (f3 == 3'd3) return EC_D;
                if (f3 == 3'd2) return EC_F;
                if (f3 == 3'd1) return class_on(EC_ZFHMIN) ? EC_ZFHMIN : EC_ILLEGAL;
                if (f3 == 3'd0 || f3 >= 3'd5) return EC_V;
                return EC_ILLEGAL;
            end
            OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD:
                return (f7[1:0] == 2'd1) ? EC_D : EC_F;
            OPC_OP_FP: begin
                if (class_on(EC_ZFA)) begin
                    if ((f7 == 7'h78 || f7 == 7'h79) && rs2 == 5'd1) return EC_ZFA;
                    if ((f7 == 7'h14 || f7 == 7'h15) && (f3 == 3'd2 || f3 == 3'd3)) return EC_ZFA;
                    if ((f7 == 7'h20 || f7 == 7'h21) && (rs2 == 5'd4 || rs2 == 5'd5)) return EC_ZFA;
                    if (f7 == 7'h61 && rs2 == 5'd8) return EC_ZFA;
                    if ((f7 == 7'h50 || f7 == 7'h51) && (f3 == 3'd4 || f3 == 3'd5)) return EC_ZFA;
                end
                if (class_on(EC_ZFHMIN)) begin
                    if ((f7 == 7'h20 || f7 == 7'h21) && rs2 == 5'd2) return EC_ZFHMIN;
                    if (f7 == 7'h22 && (rs2 == 5'd0 || rs2 == 5'd1)) return EC_ZFHMIN;
                    if ((f7 == 7'h72 || f7 == 7'h7A) && rs2 == 5'd0) return EC_ZFHMIN;
                end
                if (f7 == 7'h20 || f7 == 7'h21) return EC_D;
                return f7[0] ? EC_D : EC_F;
            end
            OPC_OP_V: return EC_V;
            default: return EC_ILLEGAL;
        endcase
    endfunction

    function automatic t_dec_result predict_result(logic [31:0] w);
        t_dec_result r;
        r.ext_class = classify_instr(w);
        r.enabled   = (r.ext_class == EC_ILLEGAL) ? 1'b0 : class_on(r.ext_class);
        return r;
    endfunction

    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        int unsigned sel;
        w = $urandom();
        sel = $urandom_range(99);
        if (sel < 8) return w;
        if (sel < 11) begin
            case ($urandom_range(2))
                0: return PAUSE_WORD;
                1: return WRS_NTO_WORD;
                default: return WRS_STO_WORD;
            endcase
        end
        w[6:0] = OPCODE_SET[$urandom_range(21)];
        case ($urandom_range(3))
            1: w[31:25] = FUNCT7_SET[$urandom_range(27)];
            2: w[31:26] = FUNCT6_SET[$urandom_range(6)];
            default: ;
        endcase
        if ($urandom_range(2) == 0) w[24:20] = 5'($urandom_range(8));
        if ($urandom_range(2) == 0) w[11:7] = '0;
        if ($urandom_range(3) == 0) w[19:15] = '0;
        if (w[6:0] == OPC_MISC_MEM && $urandom_range(1) == 1) w[31:20] = 12'($urandom_range(5));
        return w;
    endfunction

    task automatic send_instr(input logic [31:0] word);
        if (idle_en && $urandom_range(99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_instr_word <= word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted_q.push_back(predict_result(word));
    endtask

    // drains the pipe, then writes both registers back to back
    task automatic set_config(input logic rv64, input logic [MASK_W-1:0] mask);
        logic [MASK_W-1:0] mode_data;
        mode_data = MASK_W'($urandom());
        mode_data[0] = rv64;
        start <= 1'b0;
        @(posedge i_clk);
        while (predicted_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_RV64_MODE;
        i_cfg_data  <= mode_data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        rv64_q = rv64;
        i_cfg_index <= CFG_EXT_ENABLE;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mask_q = mask;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_corner_list();
        for (int i = 0; i < 25; i++) send_instr(CORNER_WORDS[i]);
    endtask

    task automatic test_reset_defaults();
        send_corner_list();
    endtask

    task automatic test_gated_forms();
        set_config(1'b0, '0);
        send_corner_list();
        set_config(1'b1, MASK_ALL & ~class_bit(EC_H));
        send_corner_list();
        set_config(1'b1, MASK_ALL & ~class_bit(EC_SVINVAL));
        send_corner_list();
        send_instr(32'h2600_0073);
        set_config(1'b1, MASK_ALL & ~(class_bit(EC_ZFA) | class_bit(EC_ZFHMIN) |
                   class_bit(EC_ZICBOP) | class_bit(EC_ZIHINTPAUSE) | class_bit(EC_ZAWRS)));
        send_corner_list();
    endtask

    task automatic test_random_phases();
        set_config(1'b1, MASK_ALL);
        idle_en = 1'b0;
        repeat (300) send_instr(random_instr());
        idle_en = 1'b1;
        set_config(1'b0, '0);
        repeat (140) send_instr(random_instr());
        repeat (5) begin
            set_config(1'($urandom_range(1)), MASK_W'($urandom()));
            repeat (140) send_instr(random_instr());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (predicted_q.size() == 0) begin
                $error("unexpected transaction: ext_class %0d", o_ext_class);
                mismatch_cnt++;
            end else begin
                due = predicted_q.pop_front();
                if (o_ext_class !== due.ext_class) begin
                    $error("ext_class: expected %0d, actual %0d", due.ext_class, o_ext_class);
                    mismatch_cnt++;
                end
                if (o_class_enabled !== due.enabled) begin
                    $error("class_enabled: expected %0b, actual %0b", due.enabled,
                           o_class_enabled);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** riscv_extension_classifier_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_gated_forms();
        test_random_phases();
        start <= 1'b0;
        @(posedge i_clk);
        while (predicted_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_cnt == 0 && predicted_q.size() == 0) begin
            $display("** riscv_extension_classifier_unit: PASSED **");
        end else begin
            $display("** riscv_extension_classifier_unit: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
